// ----- rtl/core/fdu_pkg.sv -----
// Shared types and constants for the flow de-duplication / uplink assignment block.
// Holds field widths, config register indexes, the controller state type and the
// command and status bundles between the controller and the datapath.
package fdu_pkg;

   // Parameter defaults
   localparam int DEF_NODES     = 1024;
   localparam int DEF_LEAVES    = 128;
   localparam int DEF_MAX_PORTS = 64;

   // Field widths
   localparam int NODE_W  = 10;
   localparam int PORTS_W = 7;
   localparam int HOSTS_W = 11;
   localparam int CSR_W   = 11;
   localparam int SIZE_W  = PORTS_W + HOSTS_W;  // leaf size, also holds NODES
   localparam int COUNT_W = 21;
   localparam int STEP_W  = $clog2(NODE_W + 1);

   localparam logic [COUNT_W-1:0]        COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic signed [PORTS_W-1:0] PORT_NONE = -7'sd1;

   // Result kinds
   localparam logic KIND_FLOW  = 1'b0;
   localparam logic KIND_TOTAL = 1'b1;

   // Config register indexes
   localparam logic CSR_IDX_PORTS = 1'b0;
   localparam logic CSR_IDX_HOSTS = 1'b1;

   // Divisor select for the shared divider
   typedef enum logic [1:0] {
      DIV_NODE,
      DIV_LEAF,
      DIV_CNT
   } div_sel_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD_GO,
      S_MOD_RUN,
      S_BM_RD,
      S_BM_CHK,
      S_LEAF_RUN,
      S_DECIDE,
      S_CNT_GO,
      S_CNT_RUN,
      S_EMIT,
      S_TOTAL
   } fdu_state_type;

   typedef struct packed {
      logic        load_item;
      logic        div_start;
      div_sel_type div_sel;
      logic        pair_load;
      logic        bm_rd;
      logic        bm_set;
      logic        leaf_load;
      logic        cnt_rd;
      logic        cnt_wr;
      logic        emit_flow;
      logic        emit_total;
      logic        sweep_en;
   } fdu_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic bm_hit;
      logic need_cnt;
      logic sweep_last;
      logic out_free;
   } fdu_status_type;

endpackage

// ----- rtl/core/flow_dedup_uplink_round_robin_core.sv -----
// Flow de-duplication with per-leaf round-robin uplink assignment, top level.
// Joins fdu_ctrl and fdu_datapath; depends on fdu_pkg.
//
// Input beats (req_*) carry a command and a node pair; output beats (rsp_*)
// carry one result. A repeated pair is dropped and yields no output beat.
// An end-of-job beat yields the distinct-flow count and clears the count and memories.
// The csr_* port writes ports_per_leaf (index 0) and hosts_per_port (index 1).
//
// One item is in work at a time. A flow whose nodes share a leaf, or whose
// source leaf is out of range, takes two passes of the shared one-bit-per-cycle
// divider (node reduction, leaf index); a flow that uses a round-robin counter
// takes a third (counter reduction). Each pass is 10 steps, and the bitmap
// read-modify-write overlaps the leaf index pass. A dropped pair leaves after
// the node reduction pass and the bitmap read.
// After reset and after every end-of-job beat a clearing pass sweeps the
// bitmap and counter memories, one word per cycle, with req_ready low; csr
// writes are still taken.
// A stalled receiver holds the result register; the next item is accepted
// and worked on, and waits only when its own result is ready to load.
module flow_dedup_uplink_round_robin_core
   import fdu_pkg::*;
#(
   parameter int NODES     = DEF_NODES,
   parameter int LEAVES    = DEF_LEAVES,
   parameter int MAX_PORTS = DEF_MAX_PORTS
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [NODE_W-1:0]         req_src_node,
   input  logic [NODE_W-1:0]         req_dst_node,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_kind,
   output logic [NODE_W-1:0]         rsp_flow_src,
   output logic [NODE_W-1:0]         rsp_flow_dst,
   output logic signed [PORTS_W-1:0] rsp_uplink_port,
   output logic                      rsp_leaf_error,
   output logic [COUNT_W-1:0]        rsp_unique_count,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   fdu_cmd_type    cmd;
   fdu_status_type status;

   fdu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fdu_datapath #(
      .NODES     (NODES),
      .LEAVES    (LEAVES),
      .MAX_PORTS (MAX_PORTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_src_node     (req_src_node),
      .req_dst_node     (req_dst_node),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_flow_src     (rsp_flow_src),
      .rsp_flow_dst     (rsp_flow_dst),
      .rsp_uplink_port  (rsp_uplink_port),
      .rsp_leaf_error   (rsp_leaf_error),
      .rsp_unique_count (rsp_unique_count)
   );

`ifndef SYNTHESIS
   // a result is loaded only when the result register is free
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_flow || cmd.emit_total) |-> status.out_free)
      else $error("result loaded over a pending beat");

   // a pair already seen is never written back or counted
   a_no_dup_set: assert property (@(posedge clock) disable iff (reset)
      cmd.bm_set |-> !status.bm_hit)
      else $error("bitmap update on a repeated pair");

   // counter write-back only after the reduction pass has finished
   a_cnt_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_wr |-> (!status.div_busy && status.need_cnt))
      else $error("counter written during divide");

   // an output beat appears only after a load command
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit_flow || cmd.emit_total))
      else $error("output beat without a load");
`endif

endmodule

// ----- rtl/core/fdu_div.sv -----
// Two-lane restoring divider, one quotient bit per lane per cycle, shared divisor.
// Depends on fdu_pkg for widths.
module fdu_div
   import fdu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NODE_W-1:0] dividend_a,
   input  logic [NODE_W-1:0] dividend_b,
   input  logic [SIZE_W-1:0] divisor,
   output logic              busy,
   output logic [NODE_W-1:0] quo_a,
   output logic [NODE_W-1:0] quo_b,
   output logic [NODE_W-1:0] rem_a,
   output logic [NODE_W-1:0] rem_b
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [SIZE_W-1:0] divisor_ff;
   logic [NODE_W-1:0] quo_a_ff, quo_a_in, quo_b_ff, quo_b_in;
   logic [NODE_W-1:0] rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [NODE_W:0]   shift_a, shift_b;
   logic [SIZE_W-1:0] diff_a, diff_b;
   logic              ge_a, ge_b;

   // One restoring step per lane
   always_comb begin
      shift_a = {rem_a_ff, quo_a_ff[NODE_W-1]};
      shift_b = {rem_b_ff, quo_b_ff[NODE_W-1]};
      ge_a    = SIZE_W'(shift_a) >= divisor_ff;
      ge_b    = SIZE_W'(shift_b) >= divisor_ff;
      diff_a  = SIZE_W'(shift_a) - divisor_ff;
      diff_b  = SIZE_W'(shift_b) - divisor_ff;
   end

   always_comb begin
      step_in  = step_ff;
      quo_a_in = quo_a_ff;
      quo_b_in = quo_b_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      if (start) begin
         step_in  = STEP_W'(NODE_W);
         quo_a_in = dividend_a;
         quo_b_in = dividend_b;
         rem_a_in = '0;
         rem_b_in = '0;
      end else if (step_ff != '0) begin
         step_in  = step_ff - 1'b1;
         quo_a_in = {quo_a_ff[NODE_W-2:0], ge_a};
         quo_b_in = {quo_b_ff[NODE_W-2:0], ge_b};
         rem_a_in = ge_a ? diff_a[NODE_W-1:0] : shift_a[NODE_W-1:0];
         rem_b_in = ge_b ? diff_b[NODE_W-1:0] : shift_b[NODE_W-1:0];
      end
   end

   // Step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (start) begin
         divisor_ff <= divisor;
      end
      quo_a_ff <= quo_a_in;
      quo_b_ff <= quo_b_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
   end

   assign busy  = step_ff != '0;
   assign quo_a = quo_a_ff;
   assign quo_b = quo_b_ff;
   assign rem_a = rem_a_ff;
   assign rem_b = rem_b_ff;

endmodule

// ----- rtl/core/fdu_datapath.sv -----
// Datapath: config registers, item registers, seen-pair bitmap memory, per-leaf
// round-robin counter memory, flow count and the result register.
// Depends on fdu_pkg and fdu_div.
module fdu_datapath
   import fdu_pkg::*;
#(
   parameter int NODES     = DEF_NODES,
   parameter int LEAVES    = DEF_LEAVES,
   parameter int MAX_PORTS = DEF_MAX_PORTS
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  fdu_cmd_type                 cmd,
   output fdu_status_type              status,
   input  logic [NODE_W-1:0]           req_src_node,
   input  logic [NODE_W-1:0]           req_dst_node,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [CSR_W-1:0]            csr_wdata,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_kind,
   output logic [NODE_W-1:0]           rsp_flow_src,
   output logic [NODE_W-1:0]           rsp_flow_dst,
   output logic signed [PORTS_W-1:0]   rsp_uplink_port,
   output logic                        rsp_leaf_error,
   output logic [COUNT_W-1:0]          rsp_unique_count
);

   localparam int WORDS    = (NODES * NODES + 63) / 64;
   localparam int WADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PW       = WADDR_W + 6;
   localparam int LEAF_W   = (LEAVES > 1) ? $clog2(LEAVES) : 1;
   localparam int PMAX     = (MAX_PORTS < 127) ? MAX_PORTS : 127;
   localparam int CNT_W    = (PMAX > 1) ? $clog2(PMAX) : 1;
   localparam int SWEEP_N  = (WORDS > LEAVES) ? WORDS : LEAVES;
   localparam int SW_W     = (SWEEP_N > 1) ? $clog2(SWEEP_N) : 1;

   // Config registers
   logic [PORTS_W-1:0] ports_cfg_ff;
   logic [HOSTS_W-1:0] hosts_cfg_ff;
   logic [PORTS_W-1:0] ports_eff;
   logic [HOSTS_W-1:0] hosts_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ports_cfg_ff <= PORTS_W'(1);
         hosts_cfg_ff <= HOSTS_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IDX_PORTS: ports_cfg_ff <= csr_wdata[PORTS_W-1:0];
            CSR_IDX_HOSTS: hosts_cfg_ff <= csr_wdata[HOSTS_W-1:0];
            default:       ports_cfg_ff <= ports_cfg_ff;
         endcase
      end
   end

   // Zero means one, ports clamp at MAX_PORTS
   always_comb begin
      if (ports_cfg_ff == '0) begin
         ports_eff = PORTS_W'(1);
      end else if (9'(ports_cfg_ff) > 9'(MAX_PORTS)) begin
         ports_eff = PORTS_W'(MAX_PORTS);
      end else begin
         ports_eff = ports_cfg_ff;
      end
      hosts_eff = (hosts_cfg_ff == '0) ? HOSTS_W'(1) : hosts_cfg_ff;
   end

   // Item registers and leaf size
   logic [NODE_W-1:0] src_ff, dst_ff;
   logic [SIZE_W-1:0] leaf_size_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         src_ff       <= req_src_node;
         dst_ff       <= req_dst_node;
         leaf_size_ff <= SIZE_W'(ports_eff) * SIZE_W'(hosts_eff);
      end
   end

   // Shared divider: node reduction, leaf index, counter reduction
   logic [CNT_W-1:0]  cnt_q_ff;
   logic [NODE_W-1:0] div_dividend_a;
   logic [SIZE_W-1:0] div_divisor;
   logic              div_busy;
   logic [NODE_W-1:0] quo_a, quo_b, rem_a, rem_b;

   always_comb begin
      div_dividend_a = src_ff;
      div_divisor    = SIZE_W'(NODES);
      case (cmd.div_sel)
         DIV_NODE: begin
            div_dividend_a = src_ff;
            div_divisor    = SIZE_W'(NODES);
         end
         DIV_LEAF: begin
            div_dividend_a = src_ff;
            div_divisor    = leaf_size_ff;
         end
         DIV_CNT: begin
            div_dividend_a = NODE_W'(cnt_q_ff);
            div_divisor    = SIZE_W'(ports_eff);
         end
         default: begin
            div_dividend_a = src_ff;
            div_divisor    = SIZE_W'(NODES);
         end
      endcase
   end

   fdu_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.div_start),
      .dividend_a (div_dividend_a),
      .dividend_b (dst_ff),
      .divisor    (div_divisor),
      .busy       (div_busy),
      .quo_a      (quo_a),
      .quo_b      (quo_b),
      .rem_a      (rem_a),
      .rem_b      (rem_b)
   );

   // Pair index from the reduced nodes
   logic [PW-1:0] pair_ff;

   always_ff @(posedge clock) begin
      if (cmd.pair_load) begin
         pair_ff <= PW'(rem_a) * PW'(NODES) + PW'(rem_b);
      end
   end

   // Sweep counter for the clearing pass
   logic [SW_W-1:0] sweep_ff;
   logic            sweep_last;
   logic            sweep_bm_ok, sweep_cnt_ok;

   assign sweep_last   = sweep_ff == SW_W'(SWEEP_N - 1);
   assign sweep_bm_ok  = {1'b0, sweep_ff} < (SW_W + 1)'(WORDS);
   assign sweep_cnt_ok = {1'b0, sweep_ff} < (SW_W + 1)'(LEAVES);

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_en) begin
         sweep_ff <= sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   // Seen-pair bitmap memory
   logic [63:0]        bm_mem [WORDS];
   logic [63:0]        bm_q_ff;
   logic [63:0]        bm_mask;
   logic [WADDR_W-1:0] pair_word;

   assign pair_word = pair_ff[PW-1:6];
   assign bm_mask   = 64'(1) << pair_ff[5:0];

   always_ff @(posedge clock) begin
      if (cmd.bm_rd) begin
         bm_q_ff <= bm_mem[pair_word];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_en && sweep_bm_ok) begin
         bm_mem[sweep_ff[WADDR_W-1:0]] <= '0;
      end else if (cmd.bm_set) begin
         bm_mem[pair_word] <= bm_q_ff | bm_mask;
      end
   end

   // Distinct-flow count, saturating
   logic [COUNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.emit_total) begin
         count_ff <= '0;
      end else if (cmd.bm_set && count_ff != COUNT_MAX) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // Leaf decision
   logic [NODE_W-1:0]          src_leaf_ff;
   logic                       err_ff;
   logic                       need_cnt_ff;
   logic signed [PORTS_W-1:0]  port_ff;
   logic                       leaf_err;
   logic [PORTS_W-1:0]         rr_cur;
   logic [PORTS_W:0]           rr_inc;
   logic [PORTS_W-1:0]         rr_next;

   assign leaf_err = {1'b0, quo_a} >= (NODE_W + 1)'(LEAVES);
   assign rr_cur   = rem_a[PORTS_W-1:0];
   assign rr_inc   = {1'b0, rr_cur} + 1'b1;
   assign rr_next  = (rr_inc == {1'b0, ports_eff}) ? '0 : rr_inc[PORTS_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.leaf_load) begin
         src_leaf_ff <= quo_a;
         err_ff      <= leaf_err;
         need_cnt_ff <= (quo_a != quo_b) && !leaf_err;
         port_ff     <= PORT_NONE;
      end else if (cmd.cnt_wr) begin
         port_ff     <= signed'(rr_cur);
      end
   end

   // Round-robin counter memory
   logic [CNT_W-1:0] cnt_mem [LEAVES];

   always_ff @(posedge clock) begin
      if (cmd.cnt_rd) begin
         cnt_q_ff <= cnt_mem[src_leaf_ff[LEAF_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_en && sweep_cnt_ok) begin
         cnt_mem[sweep_ff[LEAF_W-1:0]] <= '0;
      end else if (cmd.cnt_wr) begin
         cnt_mem[src_leaf_ff[LEAF_W-1:0]] <= rr_next[CNT_W-1:0];
      end
   end

   // Result register
   logic                      rsp_valid_ff;
   logic                      kind_ff;
   logic [NODE_W-1:0]         out_src_ff, out_dst_ff;
   logic signed [PORTS_W-1:0] out_port_ff;
   logic                      out_err_ff;
   logic [COUNT_W-1:0]        out_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_flow || cmd.emit_total) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_flow) begin
         kind_ff      <= KIND_FLOW;
         out_src_ff   <= src_ff;
         out_dst_ff   <= dst_ff;
         out_port_ff  <= port_ff;
         out_err_ff   <= err_ff;
         out_count_ff <= '0;
      end else if (cmd.emit_total) begin
         kind_ff      <= KIND_TOTAL;
         out_src_ff   <= '0;
         out_dst_ff   <= '0;
         out_port_ff  <= '0;
         out_err_ff   <= 1'b0;
         out_count_ff <= count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_flow_src     = out_src_ff;
   assign rsp_flow_dst     = out_dst_ff;
   assign rsp_uplink_port  = out_port_ff;
   assign rsp_leaf_error   = out_err_ff;
   assign rsp_unique_count = out_count_ff;

   // Status back to the controller
   always_comb begin
      status.div_busy   = div_busy;
      status.bm_hit     = |(bm_q_ff & bm_mask);
      status.need_cnt   = need_cnt_ff;
      status.sweep_last = sweep_last;
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

// ----- rtl/core/fdu_ctrl.sv -----
// Controller: sequences the clearing sweep, the divider passes, the bitmap
// read-modify-write, the counter update and the result load.
// Depends on fdu_pkg.
module fdu_ctrl
   import fdu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_cmd,
   output logic           req_ready,
   input  fdu_status_type status,
   output fdu_cmd_type    cmd
);

   fdu_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:    if (status.sweep_last) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               state_in = req_cmd ? S_TOTAL : S_MOD_GO;
            end
         end
         S_MOD_GO:   state_in = S_MOD_RUN;
         S_MOD_RUN:  if (!status.div_busy) state_in = S_BM_RD;
         S_BM_RD:    state_in = S_BM_CHK;
         S_BM_CHK:   state_in = status.bm_hit ? S_IDLE : S_LEAF_RUN;
         S_LEAF_RUN: if (!status.div_busy) state_in = S_DECIDE;
         S_DECIDE:   state_in = status.need_cnt ? S_CNT_GO : S_EMIT;
         S_CNT_GO:   state_in = S_CNT_RUN;
         S_CNT_RUN:  if (!status.div_busy) state_in = S_EMIT;
         S_EMIT:     if (status.out_free) state_in = S_IDLE;
         S_TOTAL:    if (status.out_free) state_in = S_CLEAR;
         default:    state_in = S_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR:    cmd.sweep_en = 1'b1;
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         S_MOD_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_NODE;
         end
         S_MOD_RUN: begin
            // leaf pass starts as soon as the pair index is taken
            if (!status.div_busy) begin
               cmd.pair_load = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_LEAF;
            end
         end
         S_BM_RD:    cmd.bm_rd = 1'b1;
         S_BM_CHK:   cmd.bm_set = !status.bm_hit;
         S_LEAF_RUN: cmd.leaf_load = !status.div_busy;
         S_DECIDE:   cmd.cnt_rd = status.need_cnt;
         S_CNT_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_CNT;
         end
         S_CNT_RUN: begin
            cmd.div_sel = DIV_CNT;
            cmd.cnt_wr  = !status.div_busy;
         end
         S_EMIT:     cmd.emit_flow = status.out_free;
         S_TOTAL:    cmd.emit_total = status.out_free;
         default:    cmd = '0;
      endcase
   end

endmodule

// ----- tb/tb_flow_dedup_uplink_round_robin_core.sv -----
// Testbench for flow_dedup_uplink_round_robin_core: directed table, then random job phases.
// Results are checked against an in-bench uplink predictor or typed rows; depends on fdu_pkg and the RTL.
module tb_flow_dedup_uplink_round_robin_core;
   import fdu_pkg::*;

   localparam int     CLK_PERIOD    = 12;
   localparam longint LIMIT_CYCLES  = 2_500_000;
   localparam int     SETTLE_CYCLES = 64;
   localparam int     RANDOM_ITEMS  = 1730;
   localparam int     TAIL_ITEMS    = 150;
   localparam int     EOJ_BUDGET    = 18;
   localparam int     POOL_DEPTH    = 64;

   localparam logic CMD_FLOW    = 1'b0;
   localparam logic CMD_END_JOB = 1'b1;

   typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_t;
   typedef enum logic [1:0] {CHK_MODEL, CHK_TYPED, CHK_NONE} chk_mode_t;

   typedef struct packed {
      logic                      kind;
      logic [NODE_W-1:0]         src;
      logic [NODE_W-1:0]         dst;
      logic signed [PORTS_W-1:0] port;
      logic                      err;
      logic [COUNT_W-1:0]        count;
   } flow_result_t;

   typedef struct packed {
      row_kind_t         kind;
      logic              cmd;
      logic [NODE_W-1:0] src;
      logic [NODE_W-1:0] dst;
      logic [CSR_W-1:0]  ports_wd;
      logic [CSR_W-1:0]  hosts_wd;
      chk_mode_t         mode;
      flow_result_t      typed;
   } stim_row_t;

   // Directed rows; typed results only where they are obvious
   localparam stim_row_t DIRECTED_TBL [0:24] = '{
      // reset config: leaf size 1
      '{ROW_ITEM, CMD_FLOW, 10'd0, 10'd0, 11'd0, 11'd0, CHK_TYPED,
        '{KIND_FLOW, 10'd0, 10'd0, PORT_NONE, 1'b0, 21'd0}},
      // repeated pair is dropped
      '{ROW_ITEM, CMD_FLOW, 10'd0, 10'd0, 11'd0, 11'd0, CHK_NONE, '0},
      '{ROW_ITEM, CMD_FLOW, 10'd1023, 10'd1023, 11'd0, 11'd0, CHK_TYPED,
        '{KIND_FLOW, 10'd1023, 10'd1023, PORT_NONE, 1'b1, 21'd0}},
      '{ROW_ITEM, CMD_FLOW, 10'd0, 10'd1, 11'd0, 11'd0, CHK_TYPED,
        '{KIND_FLOW, 10'd0, 10'd1, 7'sd0, 1'b0, 21'd0}},
      '{ROW_ITEM, CMD_FLOW, 10'd0, 10'd2, 11'd0, 11'd0, CHK_TYPED,
        '{KIND_FLOW, 10'd0, 10'd2, 7'sd0, 1'b0, 21'd0}},
      // source leaf out of table, leaves differ
      '{ROW_ITEM, CMD_FLOW, 10'd200, 10'd5, 11'd0, 11'd0, CHK_TYPED,
        '{KIND_FLOW, 10'd200, 10'd5, PORT_NONE, 1'b1, 21'd0}},
      '{ROW_ITEM, CMD_FLOW, 10'd1023, 10'd0, 11'd0, 11'd0, CHK_TYPED,
        '{KIND_FLOW, 10'd1023, 10'd0, PORT_NONE, 1'b1, 21'd0}},
      // end of job ignores its nodes
      '{ROW_ITEM, CMD_END_JOB, 10'd1023, 10'd1023, 11'd0, 11'd0, CHK_TYPED,
        '{KIND_TOTAL, 10'd0, 10'd0, 7'sd0, 1'b0, 21'd6}},
      // bitmap was cleared
      '{ROW_ITEM, CMD_FLOW, 10'd0, 10'd0, 11'd0, 11'd0, CHK_TYPED,
        '{KIND_FLOW, 10'd0, 10'd0, PORT_NONE, 1'b0, 21'd0}},
      // leaf size 8, round robin over 4 ports
      '{ROW_CFG, CMD_FLOW, 10'd0, 10'd0, 11'd4, 11'd2, CHK_MODEL, '0},
      '{ROW_ITEM, CMD_FLOW, 10'd0, 10'd8, 11'd0, 11'd0, CHK_MODEL, '0},
      '{ROW_ITEM, CMD_FLOW, 10'd1, 10'd9, 11'd0, 11'd0, CHK_MODEL, '0},
      '{ROW_ITEM, CMD_FLOW, 10'd2, 10'd10, 11'd0, 11'd0, CHK_MODEL, '0},
      '{ROW_ITEM, CMD_FLOW, 10'd3, 10'd11, 11'd0, 11'd0, CHK_MODEL, '0},
      '{ROW_ITEM, CMD_FLOW, 10'd4, 10'd12, 11'd0, 11'd0, CHK_MODEL, '0},
      '{ROW_ITEM, CMD_FLOW, 10'd9, 10'd1, 11'd0, 11'd0, CHK_MODEL, '0},
      '{ROW_ITEM, CMD_FLOW, 10'd0, 10'd8, 11'd0, 11'd0, CHK_NONE, '0},
      // zero ports and hosts act as one; stored counter reduced mid-job
      '{ROW_CFG, CMD_FLOW, 10'd0, 10'd0, 11'd0, 11'd0, CHK_MODEL, '0},
      '{ROW_ITEM, CMD_FLOW, 10'd0, 10'd20, 11'd0, 11'd0, CHK_MODEL, '0},
      // ports clamp to max, huge leaf: every node in leaf 0
      '{ROW_CFG, CMD_FLOW, 10'd0, 10'd0, 11'd127, 11'd2047, CHK_MODEL, '0},
      '{ROW_ITEM, CMD_FLOW, 10'd1023, 10'd0, 11'd0, 11'd0, CHK_MODEL, '0},
      // upper write bits dropped for ports: 65 clamps to 64
      '{ROW_CFG, CMD_FLOW, 10'd0, 10'd0, 11'h7C1, 11'd1, CHK_MODEL, '0},
      '{ROW_ITEM, CMD_FLOW, 10'd1023, 10'd0, 11'd0, 11'd0, CHK_MODEL, '0},
      '{ROW_ITEM, CMD_FLOW, 10'd1023, 10'd64, 11'd0, 11'd0, CHK_MODEL, '0},
      '{ROW_ITEM, CMD_END_JOB, 10'h2AA, 10'h155, 11'd0, 11'd0, CHK_MODEL, '0}
   };

   // DUT signals
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_cmd = 1'b0;
   logic [NODE_W-1:0]         req_src_node = '0;
   logic [NODE_W-1:0]         req_dst_node = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_kind;
   logic [NODE_W-1:0]         rsp_flow_src;
   logic [NODE_W-1:0]         rsp_flow_dst;
   logic signed [PORTS_W-1:0] rsp_uplink_port;
   logic                      rsp_leaf_error;
   logic [COUNT_W-1:0]        rsp_unique_count;
   logic                      csr_we = 1'b0;
   logic                      csr_index = CSR_IDX_PORTS;
   logic [CSR_W-1:0]          csr_wdata = '0;

   // Predictor state
   logic [PORTS_W-1:0] cfg_ports;
   logic [HOSTS_W-1:0] cfg_hosts;
   bit                 seen_pairs [int unsigned];
   logic [5:0]         leaf_rr [0:DEF_LEAVES-1];
   logic [COUNT_W-1:0] job_flow_count;

   flow_result_t due_uplink_results [$];
   flow_result_t head_result;
   int           fail_count = 0;
   int           gap_pct = 0;
   int           rsp_idle_pct = 0;
   int           ready_hold = 0;

   flow_dedup_uplink_round_robin_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_src_node     (req_src_node),
      .req_dst_node     (req_dst_node),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_flow_src     (rsp_flow_src),
      .rsp_flow_dst     (rsp_flow_dst),
      .rsp_uplink_port  (rsp_uplink_port),
      .rsp_leaf_error   (rsp_leaf_error),
      .rsp_unique_count (rsp_unique_count),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Clear the job: bitmap, leaf counters, distinct count
   function automatic void clear_job_state();
      seen_pairs.delete();
      foreach (leaf_rr[i]) leaf_rr[i] = '0;
      job_flow_count = '0;
   endfunction

   // Expected result of one beat; updates the predictor state
   function automatic void predict_uplink(input logic cmd, input logic [NODE_W-1:0] src,
                                          input logic [NODE_W-1:0] dst,
                                          output bit produced, output flow_result_t res);
      int unsigned ports;
      int unsigned hosts;
      int unsigned leaf_size;
      int unsigned src_leaf;
      int unsigned dst_leaf;
      int unsigned pair_key;
      int unsigned rr;
      res = '0;
      produced = 1'b0;
      if (cmd == CMD_END_JOB) begin
         res.kind = KIND_TOTAL;
         res.count = job_flow_count;
         clear_job_state();
         produced = 1'b1;
         return;
      end
      pair_key = src * DEF_NODES + dst;
      if (seen_pairs.exists(pair_key)) return;
      seen_pairs[pair_key] = 1'b1;
      if (job_flow_count != COUNT_MAX) job_flow_count = job_flow_count + 1'b1;

      ports = (cfg_ports == 0) ? 1 : int'(cfg_ports);
      if (ports > DEF_MAX_PORTS) ports = DEF_MAX_PORTS;
      hosts = (cfg_hosts == 0) ? 1 : int'(cfg_hosts);
      leaf_size = ports * hosts;
      src_leaf = src / leaf_size;
      dst_leaf = dst / leaf_size;

      res.kind = KIND_FLOW;
      res.src = src;
      res.dst = dst;
      res.port = PORT_NONE;
      res.err = (src_leaf >= DEF_LEAVES);
      if (src_leaf != dst_leaf && !res.err) begin
         rr = leaf_rr[src_leaf] % ports;
         res.port = PORTS_W'(rr);
         leaf_rr[src_leaf] = 6'((rr + 1) % ports);
      end
      produced = 1'b1;
   endfunction

   // One input beat: optional gap, hold valid until taken, then predict
   task automatic send_beat(input logic cmd, input logic [NODE_W-1:0] src,
                            input logic [NODE_W-1:0] dst, input chk_mode_t mode,
                            input flow_result_t typed);
      bit           produced;
      flow_result_t res;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_src_node <= src;
      req_dst_node <= dst;
      do @(posedge clock); while (!req_ready);
      predict_uplink(cmd, src, dst, produced, res);
      case (mode)
         CHK_MODEL: if (produced) due_uplink_results.push_back(res);
         CHK_TYPED: due_uplink_results.push_back(typed);
         default: ;
      endcase
   endtask

   // Sender pauses until every result is back and the block has settled
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (due_uplink_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers, ports then hosts
   task automatic write_config(input logic [CSR_W-1:0] ports_wd,
                               input logic [CSR_W-1:0] hosts_wd);
      csr_we    <= 1'b1;
      csr_index <= CSR_IDX_PORTS;
      csr_wdata <= ports_wd;
      @(posedge clock);
      csr_index <= CSR_IDX_HOSTS;
      csr_wdata <= hosts_wd;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_ports = ports_wd[PORTS_W-1:0];
      cfg_hosts = hosts_wd[HOSTS_W-1:0];
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
         fail_count++;
      end
   endtask

   // Result side: random stall bursts, check each accepted beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_uplink_results.size() == 0) begin
            $error("result beat with nothing outstanding: kind %0d src %0d dst %0d",
                   rsp_kind, rsp_flow_src, rsp_flow_dst);
            fail_count++;
         end else begin
            head_result = due_uplink_results.pop_front();
            check_field("kind", head_result.kind, rsp_kind);
            check_field("flow_src", head_result.src, rsp_flow_src);
            check_field("flow_dst", head_result.dst, rsp_flow_dst);
            check_field("uplink_port", head_result.port, rsp_uplink_port);
            check_field("leaf_error", head_result.err, rsp_leaf_error);
            check_field("unique_count", head_result.count, rsp_unique_count);
         end
      end
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= 1'b0;
      end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
         ready_hold <= $urandom_range(0, 9);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Stimulus
   initial begin
      logic [CSR_W-1:0]  ports_wd;
      logic [CSR_W-1:0]  hosts_wd;
      logic              cmd;
      logic [NODE_W-1:0] src;
      logic [NODE_W-1:0] dst;
      logic [2*NODE_W-1:0] pair_pool [$];
      int                sent_cnt;
      int                eoj_left;
      int                phase_len;
      int                pick;
      bit                is_repeat;

      cfg_ports = PORTS_W'(1);
      cfg_hosts = HOSTS_W'(1);
      clear_job_state();
      sent_cnt = 0;
      eoj_left = EOJ_BUDGET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      rsp_idle_pct = 20;
      foreach (DIRECTED_TBL[i]) begin
         if (DIRECTED_TBL[i].kind == ROW_CFG) begin
            wait_until_idle();
            write_config(DIRECTED_TBL[i].ports_wd, DIRECTED_TBL[i].hosts_wd);
         end else begin
            send_beat(DIRECTED_TBL[i].cmd, DIRECTED_TBL[i].src, DIRECTED_TBL[i].dst,
                      DIRECTED_TBL[i].mode, DIRECTED_TBL[i].typed);
         end
      end

      // Random phases: new config each phase, job ends now and then
      while (sent_cnt < RANDOM_ITEMS) begin
         wait_until_idle();
         case ($urandom_range(0, 5))
            0: begin
               case ($urandom_range(0, 3))
                  0: ports_wd = 11'd0;
                  1: ports_wd = 11'd1;
                  2: ports_wd = 11'd64;
                  default: ports_wd = 11'd127;
               endcase
               case ($urandom_range(0, 3))
                  0: hosts_wd = 11'd0;
                  1: hosts_wd = 11'd1;
                  2: hosts_wd = 11'd1024;
                  default: hosts_wd = 11'd2047;
               endcase
            end
            4: begin
               ports_wd = {4'($urandom), 7'($urandom_range(1, 8))};
               hosts_wd = 11'd1;
            end
            5: begin
               ports_wd = CSR_W'($urandom_range(0, 2047));
               hosts_wd = CSR_W'($urandom_range(0, 2047));
            end
            default: begin
               ports_wd = CSR_W'($urandom_range(1, 16));
               hosts_wd = CSR_W'($urandom_range(1, 16));
            end
         endcase
         write_config(ports_wd, hosts_wd);

         if ($urandom_range(0, 3) == 0) begin
            gap_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            gap_pct = $urandom_range(10, 40);
            rsp_idle_pct = $urandom_range(10, 40);
         end

         phase_len = $urandom_range(40, 100);
         for (int k = 0; k < phase_len && sent_cnt < RANDOM_ITEMS; k++) begin
            if (sent_cnt + TAIL_ITEMS >= RANDOM_ITEMS) begin
               gap_pct = 0;
               rsp_idle_pct = 0;
            end
            pick = $urandom_range(0, 99);
            cmd = CMD_FLOW;
            is_repeat = 1'b0;
            if (eoj_left != 0 && $urandom_range(0, 149) == 0) begin
               cmd = CMD_END_JOB;
               src = NODE_W'($urandom_range(0, 1023));
               dst = NODE_W'($urandom_range(0, 1023));
               eoj_left--;
            end else if (pick < 25 && pair_pool.size() != 0) begin
               {src, dst} = pair_pool[$urandom_range(0, pair_pool.size() - 1)];
               is_repeat = 1'b1;
            end else begin
               // hot low sources keep a few leaf counters busy
               src = (pick < 55) ? NODE_W'($urandom_range(0, 63))
                                 : NODE_W'($urandom_range(0, 1023));
               case ($urandom_range(0, 3))
                  0: dst = src;
                  1: dst = src ^ NODE_W'($urandom_range(0, 7));
                  default: dst = NODE_W'($urandom_range(0, 1023));
               endcase
               pair_pool.push_back({src, dst});
               if (pair_pool.size() > POOL_DEPTH) void'(pair_pool.pop_front());
            end
            send_beat(cmd, src, dst, CHK_MODEL, '0);
            if (!is_repeat) sent_cnt++;
         end

         if (eoj_left != 0 && $urandom_range(0, 2) == 0) begin
            send_beat(CMD_END_JOB, NODE_W'($urandom_range(0, 1023)),
                      NODE_W'($urandom_range(0, 1023)), CHK_MODEL, '0);
            eoj_left--;
         end
      end

      wait_until_idle();
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Run limit
   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
